>>> src/dse_pkg.sv
`timescale 1ns / 1ps
// dse_pkg: shared types and constants for the wire edge synthesizer
// used by dse_front, dse_cmdq, dse_back and dshot_pwm_uart_edge_synth
package dse_pkg;

  localparam int TIME_BITS = 64;
  localparam int PORT_TIME_W = 64;
  localparam int KIND_W = 3;
  localparam int DATA_W = 16;
  localparam int SBIT_W = 20;
  localparam int GAP_W = 27;
  localparam int CFG_W = 27;
  localparam int CFG_IDX_W = 1;
  localparam int STEP_W = 26;
  localparam int HI_W = 13;
  localparam int IDX_W = 6;

  localparam logic [KIND_W-1:0] KIND_PWM = 3'd0;
  localparam logic [KIND_W-1:0] KIND_D150 = 3'd1;
  localparam logic [KIND_W-1:0] KIND_D300 = 3'd2;
  localparam logic [KIND_W-1:0] KIND_D600 = 3'd3;
  localparam logic [KIND_W-1:0] KIND_SERIAL = 3'd4;

  localparam logic [CFG_IDX_W-1:0] REG_SERIAL_BIT = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_GAP = 1'd1;

  localparam logic [SBIT_W-1:0] SERIAL_BIT_RESET = 20'd52083;
  localparam logic [GAP_W-1:0] GAP_RESET = 27'd1000000;

  localparam int US_TO_NS = 1000;
  localparam int BIT150 = 6667;
  localparam int BIT300 = 3333;
  localparam int BIT600 = 1667;
  localparam int HI1_150 = (BIT150 * 3) / 4;
  localparam int HI0_150 = (BIT150 * 3) / 8;
  localparam int HI1_300 = (BIT300 * 3) / 4;
  localparam int HI0_300 = (BIT300 * 3) / 8;
  localparam int HI1_600 = (BIT600 * 3) / 4;
  localparam int HI0_600 = (BIT600 * 3) / 8;

  localparam logic [IDX_W-1:0] DSHOT_LAST = 6'd32;
  localparam logic [IDX_W-1:0] SERIAL_LAST = 6'd9;

  typedef enum logic [1:0] {
    CK_PWM,
    CK_DSHOT,
    CK_SERIAL
  } cmd_kind_t;

  typedef enum logic [1:0] {
    BS_IDLE,
    BS_GAP_ADD,
    BS_GAP_MAX,
    BS_EDGE
  } back_state_t;

  typedef struct packed {
    cmd_kind_t             kc;
    logic [DATA_W-1:0]     data;
    logic                  idle;
    logic                  gap;
    logic [TIME_BITS-1:0]  now;
    logic [STEP_W-1:0]     step;
    logic [HI_W-1:0]       hi1;
    logic [HI_W-1:0]       hi0;
  } cmd_t;

  typedef struct packed {
    logic [TIME_BITS-1:0] t;
    logic                 level;
    logic                 last;
  } result_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;

  typedef struct packed {
    logic idle;
    logic busy_edge;
  } back_status_t;

endpackage

>>> src/dse_front.sv
`timescale 1ns / 1ps
// dse_front: decodes one input item into a command for the back end
// depends on dse_pkg
module dse_front (
  input  logic [dse_pkg::KIND_W-1:0]      kind,
  input  logic [dse_pkg::DATA_W-1:0]      data_value,
  input  logic                            idle_high,
  input  logic                            insert_gap,
  input  logic [dse_pkg::PORT_TIME_W-1:0] now_time,
  input  logic [dse_pkg::SBIT_W-1:0]      serial_bit_time,
  output dse_pkg::cmd_t                   cmd,
  output logic                            cmd_valid
);
  import dse_pkg::*;

  logic [STEP_W-1:0] pwm_ns;

  assign pwm_ns = STEP_W'(data_value) * STEP_W'(US_TO_NS);

  always_comb begin
    cmd = '0;
    cmd.kc = CK_PWM;
    cmd.data = data_value;
    cmd.idle = idle_high;
    cmd.gap = insert_gap;
    cmd.now = now_time[TIME_BITS-1:0];
    cmd_valid = 1'b1;
    case (kind)
      KIND_PWM: begin
        cmd.kc = CK_PWM;
        cmd.step = pwm_ns;
      end
      KIND_D150: begin
        cmd.kc = CK_DSHOT;
        cmd.step = STEP_W'(BIT150);
        cmd.hi1 = HI_W'(HI1_150);
        cmd.hi0 = HI_W'(HI0_150);
      end
      KIND_D300: begin
        cmd.kc = CK_DSHOT;
        cmd.step = STEP_W'(BIT300);
        cmd.hi1 = HI_W'(HI1_300);
        cmd.hi0 = HI_W'(HI0_300);
      end
      KIND_D600: begin
        cmd.kc = CK_DSHOT;
        cmd.step = STEP_W'(BIT600);
        cmd.hi1 = HI_W'(HI1_600);
        cmd.hi0 = HI_W'(HI0_600);
      end
      KIND_SERIAL: begin
        cmd.kc = CK_SERIAL;
        cmd.step = STEP_W'(serial_bit_time);
      end
      default: begin
        cmd_valid = 1'b0;
      end
    endcase
  end

endmodule

>>> src/dse_cmdq.sv
`timescale 1ns / 1ps
// dse_cmdq: two-entry command queue between front and back end
// depends on dse_pkg
module dse_cmdq (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 wr_en,
  input  dse_pkg::cmd_t        wr_cmd,
  input  logic                 rd_en,
  output dse_pkg::cmd_t        head,
  output dse_pkg::q_status_t   status
);
  import dse_pkg::*;

  cmd_t       q [2];
  logic       wp;
  logic       rp;
  logic [1:0] cnt;
  logic       do_wr;
  logic       do_rd;

  assign status.full = (cnt == 2'd2);
  assign status.empty = (cnt == 2'd0);
  assign do_wr = wr_en && !status.full;
  assign do_rd = rd_en && !status.empty;
  assign head = q[rp];

  always_ff @(posedge clk) begin
    if (rst) begin
      wp <= 1'b0;
      rp <= 1'b0;
      cnt <= 2'd0;
    end else begin
      if (do_wr) wp <= ~wp;
      if (do_rd) rp <= ~rp;
      case ({do_wr, do_rd})
        2'b10: cnt <= cnt + 2'd1;
        2'b01: cnt <= cnt - 2'd1;
        default: cnt <= cnt;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (do_wr) q[wp] <= wr_cmd;
  end

endmodule

>>> src/dse_back.sv
`timescale 1ns / 1ps
// dse_back: edge sequencer and two-entry result queue
// depends on dse_pkg
module dse_back (
  input  logic                       clk,
  input  logic                       rst,
  input  dse_pkg::cmd_t              head,
  input  dse_pkg::q_status_t         cq_status,
  output logic                       cmd_pop,
  input  logic [dse_pkg::GAP_W-1:0]  gap_time,
  input  logic                       res_pop,
  output dse_pkg::result_t           res,
  output logic                       res_empty,
  output dse_pkg::back_status_t      status
);
  import dse_pkg::*;

  back_state_t          state;
  back_state_t          state_next;
  cmd_t                 cur;
  logic [TIME_BITS-1:0] t;
  logic [TIME_BITS-1:0] t_next;
  logic [TIME_BITS-1:0] wend;
  logic [IDX_W-1:0]     idx;

  logic                 lvl;
  logic                 last;
  logic                 adv;
  logic [HI_W-1:0]      off;
  logic [3:0]           dsel;
  logic [3:0]           ssel;
  logic                 dbit;
  logic [TIME_BITS-1:0] start;
  result_t              edge_res;
  logic                 emit;

  result_t              oq [2];
  logic                 owp;
  logic                 orp;
  logic [1:0]           ocnt;
  logic                 oq_full;
  logic                 do_pop;

  assign oq_full = (ocnt == 2'd2);
  assign res_empty = (ocnt == 2'd0);
  assign res = oq[orp];
  assign do_pop = res_pop && !res_empty;

  assign start = (wend > head.now) ? wend : head.now;
  assign dsel = ~idx[4:1];
  assign ssel = idx[3:0] - 4'd1;
  assign dbit = cur.data[dsel];

  // edge level, offset and time step per command kind
  always_comb begin
    lvl = 1'b0;
    last = 1'b0;
    adv = 1'b0;
    off = '0;
    case (cur.kc)
      CK_PWM: begin
        last = (idx != '0);
        lvl = last ? cur.idle : 1'b1;
        adv = !last;
      end
      CK_DSHOT: begin
        last = (idx == DSHOT_LAST);
        lvl = last ? cur.idle : !idx[0];
        adv = idx[0] && !last;
        off = adv ? (dbit ? cur.hi1 : cur.hi0) : '0;
      end
      CK_SERIAL: begin
        last = (idx == SERIAL_LAST);
        adv = 1'b1;
        if (idx == '0) lvl = 1'b0;
        else if (last) lvl = 1'b1;
        else lvl = cur.data[ssel[2:0]];
      end
      default: begin
        last = 1'b1;
      end
    endcase
  end

  assign edge_res.t = t + TIME_BITS'(off);
  assign edge_res.level = lvl;
  assign edge_res.last = last;
  assign t_next = adv ? (t + TIME_BITS'(cur.step)) : t;

  always_comb begin
    state_next = state;
    cmd_pop = 1'b0;
    emit = 1'b0;
    case (state)
      BS_IDLE: begin
        if (!cq_status.empty) begin
          cmd_pop = 1'b1;
          state_next = (head.kc == CK_SERIAL && head.gap) ? BS_GAP_ADD : BS_EDGE;
        end
      end
      BS_GAP_ADD: state_next = BS_GAP_MAX;
      BS_GAP_MAX: state_next = BS_EDGE;
      BS_EDGE: begin
        emit = !oq_full;
        if (emit && last) state_next = BS_IDLE;
      end
      default: state_next = BS_IDLE;
    endcase
  end

  assign status.idle = (state == BS_IDLE);
  assign status.busy_edge = (state == BS_EDGE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= BS_IDLE;
      wend <= '0;
    end else begin
      state <= state_next;
      if (emit && last) wend <= t_next;
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      BS_IDLE: begin
        if (cmd_pop) begin
          cur <= head;
          t <= start;
          idx <= '0;
        end
      end
      BS_GAP_ADD: t <= t + TIME_BITS'(gap_time);
      BS_GAP_MAX: t <= (t > cur.now) ? t : cur.now;
      BS_EDGE: begin
        if (emit) begin
          t <= t_next;
          idx <= idx + IDX_W'(1);
        end
      end
      default: t <= t;
    endcase
  end

  // result queue
  always_ff @(posedge clk) begin
    if (rst) begin
      owp <= 1'b0;
      orp <= 1'b0;
      ocnt <= 2'd0;
    end else begin
      if (emit) owp <= ~owp;
      if (do_pop) orp <= ~orp;
      case ({emit, do_pop})
        2'b10: ocnt <= ocnt + 2'd1;
        2'b01: ocnt <= ocnt - 2'd1;
        default: ocnt <= ocnt;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (emit) oq[owp] <= edge_res;
  end

endmodule

>>> src/dshot_pwm_uart_edge_synth.sv
`timescale 1ns / 1ps
// dshot_pwm_uart_edge_synth: top level of the wire edge synthesizer
// depends on dse_pkg, dse_front, dse_cmdq, dse_back
//
// input side is a queue: a transaction happens when push is high and full
// is low. each item is a pwm pulse, a dshot150/300/600 frame or one 8n1
// serial byte, with the current time and the idle level. unused kinds are
// taken and produce nothing.
// result side is a queue: the oldest edge sits on edge_time_ns, edge_level
// and last_edge while empty is low; pop takes it.
// items are decoded and parked in a two-entry command queue; the edge
// sequencer pulls one command at a time and writes one edge per cycle into
// a two-entry result queue while that queue has room. a pushed item is
// registered, taken by the sequencer when idle and, for a serial byte
// with a gap, led through the gap add and gap max states. when pop is
// held low the result queue fills, the sequencer waits, then the command
// queue fills and full goes high. registers are written through write_en,
// reg_index and write_data; the user must write them only while the block
// is idle; the block does not enforce it. synchronous reset empties both
// queues, zeroes the stored waveform end and loads register defaults.
module dshot_pwm_uart_edge_synth (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            push,
  output logic                            full,
  input  logic [dse_pkg::KIND_W-1:0]      kind,
  input  logic [dse_pkg::DATA_W-1:0]      data_value,
  input  logic                            idle_high,
  input  logic                            insert_gap,
  input  logic [dse_pkg::PORT_TIME_W-1:0] now_time,
  output logic                            empty,
  input  logic                            pop,
  output logic [dse_pkg::PORT_TIME_W-1:0] edge_time_ns,
  output logic                            edge_level,
  output logic                            last_edge,
  input  logic                            write_en,
  input  logic [dse_pkg::CFG_IDX_W-1:0]   reg_index,
  input  logic [dse_pkg::CFG_W-1:0]       write_data
);
  import dse_pkg::*;

  logic [SBIT_W-1:0] serial_bit_time;
  logic [GAP_W-1:0]  gap_time;
  cmd_t              fr_cmd;
  logic              fr_valid;
  cmd_t              cq_head;
  q_status_t         cq_status;
  logic              cq_pop;
  result_t           res;
  back_status_t      bk_status;

  always_ff @(posedge clk) begin
    if (rst) begin
      serial_bit_time <= SERIAL_BIT_RESET;
      gap_time <= GAP_RESET;
    end else if (write_en) begin
      case (reg_index)
        REG_SERIAL_BIT: serial_bit_time <= write_data[SBIT_W-1:0];
        REG_GAP: gap_time <= write_data[GAP_W-1:0];
        default: gap_time <= gap_time;
      endcase
    end
  end

  dse_front u_front (
    .kind            (kind),
    .data_value      (data_value),
    .idle_high       (idle_high),
    .insert_gap      (insert_gap),
    .now_time        (now_time),
    .serial_bit_time (serial_bit_time),
    .cmd             (fr_cmd),
    .cmd_valid       (fr_valid)
  );

  dse_cmdq u_cmdq (
    .clk    (clk),
    .rst    (rst),
    .wr_en  (push && fr_valid),
    .wr_cmd (fr_cmd),
    .rd_en  (cq_pop),
    .head   (cq_head),
    .status (cq_status)
  );

  dse_back u_back (
    .clk       (clk),
    .rst       (rst),
    .head      (cq_head),
    .cq_status (cq_status),
    .cmd_pop   (cq_pop),
    .gap_time  (gap_time),
    .res_pop   (pop),
    .res       (res),
    .res_empty (empty),
    .status    (bk_status)
  );

  assign full = cq_status.full;
  assign edge_time_ns = PORT_TIME_W'(res.t);
  assign edge_level = res.level;
  assign last_edge = res.last;

  a_reset_empty: assert property (@(posedge clk) rst |=> (empty && !full))
    else $error("queues not empty after reset");

  a_back_takes_cmd: assert property (@(posedge clk) disable iff (rst)
    (!cq_status.empty && bk_status.idle) |=> !bk_status.idle)
    else $error("sequencer ignored a waiting command");

  a_full_after_push: assert property (@(posedge clk) disable iff (rst)
    $rose(full) |-> $past(push))
    else $error("command queue filled without a transaction");

  a_idle_no_pop: assert property (@(posedge clk) disable iff (rst)
    bk_status.busy_edge |-> !cq_pop)
    else $error("command taken while edges still pending");

endmodule
